// ===== hdl/pqat_pkg.sv =====
`default_nettype none

package pqat_pkg;

  localparam int unsigned OccW = 24;
  localparam int unsigned LenW = 12;
  localparam int unsigned DecW = 3;

  // header length kept when a data packet is trimmed
  localparam logic [LenW-1:0] TrimBytes = LenW'(128);

  // configuration register indexes
  localparam logic CfgLowLimit  = 1'b0;
  localparam logic CfgHighLimit = 1'b1;

  typedef enum logic [DecW-1:0] {
    DecLow         = 3'd0,
    DecHigh        = 3'd1,
    DecTrimHigh    = 3'd2,
    DecDropBoth    = 3'd3,
    DecDropHigh    = 3'd4,
    DecDropInvalid = 3'd5,
    DecReleased    = 3'd6
  } pqat_decision_e;

  typedef struct packed {
    logic            mode;
    logic [LenW-1:0] packet_bytes;
    logic            is_data;
    logic            is_chopped;
    logic            release_high;
  } pqat_item_t;

  typedef struct packed {
    pqat_decision_e  decision;
    logic [LenW-1:0] charged_bytes;
    logic [OccW-1:0] low_occupancy_now;
    logic [OccW-1:0] high_occupancy_now;
  } pqat_result_t;

endpackage

`default_nettype wire

// ===== hdl/pqat_if.sv =====
`default_nettype none

// packet offer / release word
interface pqat_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [pqat_pkg::LenW-1:0]   packet_bytes;
  logic                        is_data;
  logic                        is_chopped;
  logic                        release_high;

  modport source (
    output valid, mode, packet_bytes, is_data, is_chopped, release_high,
    input  ready
  );
  modport sink (
    input  valid, mode, packet_bytes, is_data, is_chopped, release_high,
    output ready
  );
endinterface

// admission result word
interface pqat_out_if;
  logic                        valid;
  logic                        ready;
  logic [pqat_pkg::DecW-1:0]   decision;
  logic [pqat_pkg::LenW-1:0]   charged_bytes;
  logic [pqat_pkg::OccW-1:0]   low_occupancy_now;
  logic [pqat_pkg::OccW-1:0]   high_occupancy_now;

  modport source (
    output valid, decision, charged_bytes, low_occupancy_now, high_occupancy_now,
    input  ready
  );
  modport sink (
    input  valid, decision, charged_bytes, low_occupancy_now, high_occupancy_now,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/pqat_decide.sv =====
`default_nettype none

module pqat_decide (
  input  var pqat_pkg::pqat_item_t        item_i,
  input  var logic [pqat_pkg::OccW-1:0]   low_occ_i,
  input  var logic [pqat_pkg::OccW-1:0]   high_occ_i,
  input  var logic [pqat_pkg::OccW-1:0]   low_limit_i,
  input  var logic [pqat_pkg::OccW-1:0]   high_limit_i,
  output pqat_pkg::pqat_result_t          res_o
);

  logic [pqat_pkg::OccW:0]   low_sum;
  logic [pqat_pkg::OccW:0]   high_sum;
  logic [pqat_pkg::OccW:0]   trim_sum;
  logic                      low_fit;
  logic                      high_fit;
  logic                      trim_fit;
  logic [pqat_pkg::OccW-1:0] rel_occ;
  logic [pqat_pkg::OccW-1:0] rel_amt;
  logic [pqat_pkg::OccW-1:0] rel_left;

  // sums are one bit wider so the strict compare never wraps
  assign low_sum  = {1'b0, low_occ_i}  + (pqat_pkg::OccW+1)'(item_i.packet_bytes);
  assign high_sum = {1'b0, high_occ_i} + (pqat_pkg::OccW+1)'(item_i.packet_bytes);
  assign trim_sum = {1'b0, high_occ_i} + (pqat_pkg::OccW+1)'(pqat_pkg::TrimBytes);

  assign low_fit  = low_sum  < {1'b0, low_limit_i};
  assign high_fit = high_sum < {1'b0, high_limit_i};
  assign trim_fit = trim_sum < {1'b0, high_limit_i};

  // saturating release on the selected counter
  assign rel_occ  = item_i.release_high ? high_occ_i : low_occ_i;
  assign rel_amt  = pqat_pkg::OccW'(item_i.packet_bytes);
  assign rel_left = (rel_amt >= rel_occ) ? '0 : (rel_occ - rel_amt);

  always_comb begin
    res_o.decision           = pqat_pkg::DecDropInvalid;
    res_o.charged_bytes      = '0;
    res_o.low_occupancy_now  = low_occ_i;
    res_o.high_occupancy_now = high_occ_i;
    priority if (item_i.mode) begin
      res_o.decision = pqat_pkg::DecReleased;
      if (item_i.release_high) begin
        res_o.high_occupancy_now = rel_left;
      end else begin
        res_o.low_occupancy_now = rel_left;
      end
    end else if (item_i.is_data && !item_i.is_chopped) begin
      priority if (low_fit) begin
        res_o.decision          = pqat_pkg::DecLow;
        res_o.charged_bytes     = item_i.packet_bytes;
        res_o.low_occupancy_now = low_sum[pqat_pkg::OccW-1:0];
      end else if (trim_fit) begin
        res_o.decision           = pqat_pkg::DecTrimHigh;
        res_o.charged_bytes      = pqat_pkg::TrimBytes;
        res_o.high_occupancy_now = trim_sum[pqat_pkg::OccW-1:0];
      end else begin
        res_o.decision = pqat_pkg::DecDropBoth;
      end
    end else if (item_i.is_data == item_i.is_chopped) begin
      if (high_fit) begin
        res_o.decision           = pqat_pkg::DecHigh;
        res_o.charged_bytes      = item_i.packet_bytes;
        res_o.high_occupancy_now = high_sum[pqat_pkg::OccW-1:0];
      end else begin
        res_o.decision = pqat_pkg::DecDropHigh;
      end
    end else begin
      // chopped control packet
      res_o.decision = pqat_pkg::DecDropInvalid;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/priority_queue_admission_with_trim.sv =====
// a word accepted into the input stage is decided from there and registered into the
//   result stage, where the result word can then be taken
// throughput: one word per cycle unless res_o.ready stalls the result stage; the occupancy
//   counters update in the same cycle that the decision is registered, so the next word
//   already sees them; the occupancy add/compare loop through the counters sets the rate
// reset: asynchronous, active low; clears valid flags, occupancy counters and both limits
`default_nettype none

module priority_queue_admission_with_trim (
  input  var logic                         clk_i,
  input  var logic                         rst_ni,
  input  var logic                         cfg_we_i,
  input  var logic                         cfg_idx_i,
  input  var logic [pqat_pkg::OccW-1:0]    cfg_wdata_i,
  pqat_in_if.sink                          pkt_i,
  pqat_out_if.source                       res_o
);

  // input stage
  logic                   in_vld_q, in_vld_d;
  pqat_pkg::pqat_item_t   in_q;
  logic                   in_take;

  // result stage
  logic                   out_vld_q, out_vld_d;
  pqat_pkg::pqat_result_t out_q;
  pqat_pkg::pqat_result_t upd;
  logic                   adv;

  // queue state and limits
  logic [pqat_pkg::OccW-1:0] low_occ_q, high_occ_q;
  logic [pqat_pkg::OccW-1:0] low_lim_q, high_lim_q;

  // result stage frees when empty or drained this cycle
  assign adv       = in_vld_q && (!out_vld_q || res_o.ready);
  assign pkt_i.ready = !in_vld_q || adv;
  assign in_take   = pkt_i.valid && pkt_i.ready;

  assign in_vld_d  = in_take || (in_vld_q && !adv);
  assign out_vld_d = adv || (out_vld_q && !res_o.ready);

  pqat_decide u_decide (
    .item_i       (in_q),
    .low_occ_i    (low_occ_q),
    .high_occ_i   (high_occ_q),
    .low_limit_i  (low_lim_q),
    .high_limit_i (high_lim_q),
    .res_o        (upd)
  );

  // control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      low_occ_q  <= '0;
      high_occ_q <= '0;
      low_lim_q  <= '0;
      high_lim_q <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (adv) begin
        low_occ_q  <= upd.low_occupancy_now;
        high_occ_q <= upd.high_occupancy_now;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pqat_pkg::CfgLowLimit:  low_lim_q  <= cfg_wdata_i;
          pqat_pkg::CfgHighLimit: high_lim_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.mode         <= pkt_i.mode;
      in_q.packet_bytes <= pkt_i.packet_bytes;
      in_q.is_data      <= pkt_i.is_data;
      in_q.is_chopped   <= pkt_i.is_chopped;
      in_q.release_high <= pkt_i.release_high;
    end
    if (adv) begin
      out_q <= upd;
    end
  end

  assign res_o.valid              = out_vld_q;
  assign res_o.decision           = out_q.decision;
  assign res_o.charged_bytes      = out_q.charged_bytes;
  assign res_o.low_occupancy_now  = out_q.low_occupancy_now;
  assign res_o.high_occupancy_now = out_q.high_occupancy_now;

  // a decision moved into the result stage is shown next cycle
  a_adv_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("result stage not loaded after advance");

  // reported occupancies match the counters written alongside them
  a_occ_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_q.low_occupancy_now == low_occ_q) &&
            (out_q.high_occupancy_now == high_occ_q))
    else $error("reported occupancy differs from counters");

  // counters only move when a word is decided
  a_occ_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(low_occ_q) && $stable(high_occ_q))
    else $error("occupancy changed without a decision");

  // drops and releases charge nothing
  a_no_charge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (out_q.decision == pqat_pkg::DecDropBoth ||
                  out_q.decision == pqat_pkg::DecDropHigh ||
                  out_q.decision == pqat_pkg::DecDropInvalid ||
                  out_q.decision == pqat_pkg::DecReleased)
      |-> out_q.charged_bytes == '0)
    else $error("nonzero charge on drop or release");

endmodule

`default_nettype wire
